// ===== hdl/wsm_pkg.sv =====
// shared types, constants and helper functions for the wildcard name matcher
`timescale 1ns / 1ps
`default_nettype none
package wsm_pkg;

    localparam int PAT_LEN = 32;
    localparam int IDX_W   = $clog2(PAT_LEN);
    localparam int LEN_W   = $clog2(PAT_LEN + 1);
    localparam int POS_W   = PAT_LEN + 1;

    localparam logic [7:0] STAR_CODE   = 8'h2A;
    localparam logic [7:0] LOWER_A     = 8'h61;
    localparam logic [7:0] LOWER_Z     = 8'h7A;
    localparam logic [7:0] UPPER_A     = 8'h41;
    localparam logic [7:0] UPPER_Z     = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = LOWER_A - UPPER_A;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_NAME   = 2'd2,
        OP_END    = 2'd3
    } op_t;

    typedef logic [PAT_LEN-1:0][7:0] pat_chars_t;

    // pattern status seen by the live tracker
    typedef struct packed {
        logic [PAT_LEN-1:0] used_mask;
        logic [PAT_LEN-1:0] star_mask;
        logic [LEN_W-1:0]   length;
        logic               overflow;
    } pat_status_t;

    // one command as applied to the matcher state
    typedef struct packed {
        logic       valid;
        op_t        op;
        logic [7:0] fchar;
    } live_cmd_t;

    // upper-case ascii letters, leave everything else alone
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= LOWER_A && c <= LOWER_Z)
        begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

    // spread live positions forward across runs of stars with one carry chain:
    // a carry into bit j means some live star position k < j has stars up to j
    function automatic logic [POS_W-1:0] star_closure(
        input logic [POS_W-1:0]   live,
        input logic [PAT_LEN-1:0] star_mask
    );
        logic [POS_W:0] a;
        logic [POS_W:0] b;
        logic [POS_W:0] carries;
        a       = {2'b00, star_mask};
        b       = {1'b0, live} & a;
        carries = (a + b) ^ a ^ b;
        return live | carries[POS_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/wsm_if.sv =====
// valid/ready channel interfaces for commands and match results
`timescale 1ns / 1ps
`default_nettype none
interface wsm_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] char_code;

    modport source (output valid, output opcode, output char_code, input ready);
    modport sink (input valid, input opcode, input char_code, output ready);
endinterface

interface wsm_res_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface
`default_nettype wire

// ===== hdl/wsm_pattern.sv =====
// pattern store: folded characters, star and used masks, length and overflow flag
`timescale 1ns / 1ps
`default_nettype none
module wsm_pattern (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire wsm_pkg::live_cmd_t            cmd,
    input  wire logic [7:0]                    raw_char,
    output wsm_pkg::pat_chars_t                chars,
    output wsm_pkg::pat_status_t               status,
    output logic [wsm_pkg::PAT_LEN-1:0]        star_next
);

    wsm_pkg::pat_chars_t                chars_reg;
    wsm_pkg::pat_status_t               status_reg;
    wsm_pkg::pat_status_t               status_next;
    logic                               room;
    logic                               do_write;
    logic [wsm_pkg::IDX_W-1:0]          wr_idx;

    assign room     = status_reg.length < wsm_pkg::LEN_W'(wsm_pkg::PAT_LEN);
    assign do_write = cmd.valid && (cmd.op == wsm_pkg::OP_APPEND) && room;
    assign wr_idx   = status_reg.length[wsm_pkg::IDX_W-1:0];

    always_comb
    begin
        status_next = status_reg;
        if (cmd.valid)
        begin
            unique case (cmd.op)
                wsm_pkg::OP_CLEAR:
                begin
                    status_next = '0;
                end
                wsm_pkg::OP_APPEND:
                begin
                    if (room)
                    begin
                        status_next.used_mask[wr_idx] = 1'b1;
                        status_next.star_mask[wr_idx] = (raw_char == wsm_pkg::STAR_CODE);
                        status_next.length = status_reg.length + wsm_pkg::LEN_W'(1);
                    end
                    else
                    begin
                        status_next.overflow = 1'b1;
                    end
                end
                default:
                begin
                    status_next = status_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= '0;
        end
        else
        begin
            status_reg <= status_next;
        end
    end

    // character bytes need no reset, only entries below length are used
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            chars_reg[wr_idx] <= cmd.fchar;
        end
    end

    assign chars     = chars_reg;
    assign status    = status_reg;
    assign star_next = status_next.star_mask;

endmodule
`default_nettype wire

// ===== hdl/wsm_live.sv =====
// live position vector: advance on a name byte, re-arm on every other command
`timescale 1ns / 1ps
`default_nettype none
module wsm_live (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire wsm_pkg::live_cmd_t            cmd,
    input  wire wsm_pkg::pat_chars_t           chars,
    input  wire wsm_pkg::pat_status_t          status,
    input  wire logic [wsm_pkg::PAT_LEN-1:0]   star_next,
    output logic [wsm_pkg::POS_W-1:0]          live
);

    logic [wsm_pkg::POS_W-1:0]   live_reg;
    logic [wsm_pkg::POS_W-1:0]   live_next;
    logic [wsm_pkg::PAT_LEN-1:0] hit_mask;
    logic [wsm_pkg::POS_W-1:0]   stepped;
    logic [wsm_pkg::POS_W-1:0]   armed;

    // positions whose literal byte equals the incoming name byte
    always_comb
    begin
        for (int i = 0; i < wsm_pkg::PAT_LEN; i++)
        begin
            hit_mask[i] = status.used_mask[i] && !status.star_mask[i]
                          && (chars[i] == cmd.fchar);
        end
    end

    // a star keeps its position, a matching literal moves one on
    assign stepped = ({1'b0, live_reg[wsm_pkg::PAT_LEN-1:0] & status.star_mask})
                   | ({live_reg[wsm_pkg::PAT_LEN-1:0] & hit_mask, 1'b0});

    assign armed = wsm_pkg::star_closure(wsm_pkg::POS_W'(1), star_next);

    always_comb
    begin
        live_next = live_reg;
        if (cmd.valid)
        begin
            if (cmd.op == wsm_pkg::OP_NAME)
            begin
                live_next = wsm_pkg::star_closure(stepped, status.star_mask);
            end
            else
            begin
                live_next = armed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= wsm_pkg::POS_W'(1);
        end
        else
        begin
            live_reg <= live_next;
        end
    end

    assign live = live_reg;

endmodule
`default_nettype wire

// ===== hdl/wildcard_star_name_match_core.sv =====
// top level of the star-only wildcard name matcher
`timescale 1ns / 1ps
`default_nettype none
// Case-insensitive wildcard matcher where only '*' is special (any run of bytes,
// including none; a run of stars acts as one star). Load a pattern with a clear
// transfer followed by append transfers, then stream a name as name-byte
// transfers and finish with an end-of-name transfer, which alone produces a
// result (matched, pattern_overflow) and re-arms the matcher. Up to 32 pattern
// bytes are kept; further appends set pattern_overflow and force matched low
// until the next clear. An append in the middle of a name drops the partial
// name. Each command is registered on accept and applied to the pattern store
// and the bit-parallel live position vector in the next cycle unless an end of
// name must wait for the result register, so one transfer per cycle is sustained
// while nothing stalls. The result sits in an output register; while it waits,
// commands other than end of name keep flowing and only a second end of name
// stalls. After reset the pattern is empty.
module wildcard_star_name_match_core (
    input  wire logic clk,
    input  wire logic rst_n,
    wsm_cmd_if.sink   cmd,
    wsm_res_if.source res
);

    // input register
    logic             s1_valid_reg;
    wsm_pkg::op_t     s1_op_reg;
    logic [7:0]       s1_char_reg;
    logic             s1_fire;

    // result register
    logic             res_valid_reg;
    logic             res_matched_reg;
    logic             res_ovf_reg;

    wsm_pkg::live_cmd_t               apply_cmd;
    wsm_pkg::pat_chars_t              chars;
    wsm_pkg::pat_status_t             status;
    logic [wsm_pkg::PAT_LEN-1:0]      star_next;
    logic [wsm_pkg::POS_W-1:0]        live;
    logic                             end_hit;

    // an end of name needs a free result slot, everything else goes straight on
    assign s1_fire = s1_valid_reg
                   && ((s1_op_reg != wsm_pkg::OP_END) || !res_valid_reg || res.ready);
    assign cmd.ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.valid && cmd.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_op_reg   <= wsm_pkg::op_t'(cmd.opcode);
            s1_char_reg <= cmd.char_code;
        end
    end

    assign apply_cmd.valid = s1_fire;
    assign apply_cmd.op    = s1_op_reg;
    assign apply_cmd.fchar = wsm_pkg::fold_case(s1_char_reg);

    wsm_pattern u_pattern (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (apply_cmd),
        .raw_char  (s1_char_reg),
        .chars     (chars),
        .status    (status),
        .star_next (star_next)
    );

    wsm_live u_live (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (apply_cmd),
        .chars     (chars),
        .status    (status),
        .star_next (star_next),
        .live      (live)
    );

    // the name matched when the end of the pattern is live
    assign end_hit = live[status.length];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_fire && (s1_op_reg == wsm_pkg::OP_END))
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && (s1_op_reg == wsm_pkg::OP_END))
        begin
            res_matched_reg <= end_hit && !status.overflow;
            res_ovf_reg     <= status.overflow;
        end
    end

    assign res.valid            = res_valid_reg;
    assign res.matched          = res_matched_reg;
    assign res.pattern_overflow = res_ovf_reg;

    // overflow can only be flagged once the store is full
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        status.overflow |-> (status.length == wsm_pkg::LEN_W'(wsm_pkg::PAT_LEN)))
        else $error("overflow flagged with room left in the pattern store");

    // no live position beyond the end of the pattern
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((live & ~{status.used_mask, 1'b1}) == '0))
        else $error("live position beyond pattern length");

    // a clear leaves an empty pattern with only the start position live
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_op_reg == wsm_pkg::OP_CLEAR))
        |=> ((status.length == '0) && (live == wsm_pkg::POS_W'(1)) && !status.overflow))
        else $error("clear did not empty the pattern");

    // a result never claims a match on an overflowed pattern
    a_res_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> !(res_matched_reg && res_ovf_reg))
        else $error("match reported with overflowed pattern");

endmodule
`default_nettype wire
